// ===== hw/rtl/humidity_band_relay_controller_macros.svh =====
// ----------------------------------------------------------------------------
// humidity band relay controller assertion macros
// concurrent assertion helpers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_BAND_RELAY_CONTROLLER_MACROS_SVH
`define HUMIDITY_BAND_RELAY_CONTROLLER_MACROS_SVH

`ifndef ASSERT_OFF

// antecedent in a cycle implies consequent in the same cycle
`define HBRC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// expression never true out of reset
`define HBRC_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed");

`else

`define HBRC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define HBRC_ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// ===== hw/rtl/hbrc_pkg.sv =====
// ----------------------------------------------------------------------------
// hbrc_pkg
// shared widths, codes, structs and the indicator colour table
// ----------------------------------------------------------------------------
`default_nettype none

package hbrc_pkg;

   localparam int TIMER_BITS   = 24;
   localparam int LEVEL_BITS   = 10;
   localparam int TIMEOUT_BITS = 24;
   localparam int MODE_BITS    = 2;
   localparam int COLOUR_BITS  = 3;
   localparam int LED_BITS     = 8;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 24;
   // timer and timeout are compared at the wider of the two widths
   localparam int CMP_BITS = (TIMER_BITS > TIMEOUT_BITS) ? TIMER_BITS : TIMEOUT_BITS;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_TARGET  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UPPER   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LOWER   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TIMEOUT = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ANODE   = 3'd4;

   // reset values
   localparam logic [LEVEL_BITS-1:0]   TARGET_RST  = 10'd500;
   localparam logic [LEVEL_BITS-1:0]   UPPER_RST   = 10'd550;
   localparam logic [LEVEL_BITS-1:0]   LOWER_RST   = 10'd450;
   localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RST = 24'd60000;

   // mode codes
   localparam logic [MODE_BITS-1:0] MODE_IDLE  = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_HUM   = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_DEHUM = 2'd2;

   // colour codes
   localparam logic [COLOUR_BITS-1:0] COL_ORANGE = 3'd0;
   localparam logic [COLOUR_BITS-1:0] COL_GREEN  = 3'd1;
   localparam logic [COLOUR_BITS-1:0] COL_PURPLE = 3'd2;
   localparam logic [COLOUR_BITS-1:0] COL_AQUA   = 3'd3;
   localparam logic [COLOUR_BITS-1:0] COL_RED    = 3'd4;
   localparam logic [COLOUR_BITS-1:0] COL_ERROR  = 3'd5;

   // input kind codes
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_TICK   = 1'b1;

   typedef struct packed {
      logic [LEVEL_BITS-1:0]   target_level;
      logic [LEVEL_BITS-1:0]   upper_limit;
      logic [LEVEL_BITS-1:0]   lower_limit;
      logic [TIMEOUT_BITS-1:0] timeout_ms;
      logic                    common_anode;
   } cfg_type;

   typedef struct packed {
      logic                  humidifier_on;
      logic                  dehumidifier_on;
      logic [MODE_BITS-1:0]  mode;
      logic                  timed_out;
      logic [LED_BITS-1:0]   led_red;
      logic [LED_BITS-1:0]   led_green;
      logic [LED_BITS-1:0]   led_blue;
   } result_type;

   // red, green, blue levels of a colour code
   function automatic logic [3*LED_BITS-1:0] colour_rgb(input logic [COLOUR_BITS-1:0] code);
      logic [3*LED_BITS-1:0] rgb;
      case (code)
         COL_ORANGE: rgb = {8'he6, 8'h5c, 8'h00};
         COL_GREEN:  rgb = {8'h44, 8'h66, 8'h00};
         COL_PURPLE: rgb = {8'h66, 8'h00, 8'hcc};
         COL_AQUA:   rgb = {8'h00, 8'h99, 8'hff};
         COL_RED:    rgb = {8'h99, 8'h00, 8'h00};
         COL_ERROR:  rgb = {8'hff, 8'h00, 8'h00};
         default:    rgb = '0;
      endcase
      return rgb;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hbrc_csr.sv =====
// ----------------------------------------------------------------------------
// hbrc_csr
// configuration register file, one write word per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module hbrc_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [hbrc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [hbrc_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output hbrc_pkg::cfg_type                         cfg
);

   hbrc_pkg::cfg_type cfg_ff;
   hbrc_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            hbrc_pkg::CSR_TARGET:
               cfg_in.target_level = csr_wdata[hbrc_pkg::LEVEL_BITS-1:0];
            hbrc_pkg::CSR_UPPER:
               cfg_in.upper_limit = csr_wdata[hbrc_pkg::LEVEL_BITS-1:0];
            hbrc_pkg::CSR_LOWER:
               cfg_in.lower_limit = csr_wdata[hbrc_pkg::LEVEL_BITS-1:0];
            hbrc_pkg::CSR_TIMEOUT:
               cfg_in.timeout_ms = csr_wdata[hbrc_pkg::TIMEOUT_BITS-1:0];
            hbrc_pkg::CSR_ANODE:
               cfg_in.common_anode = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_level <= hbrc_pkg::TARGET_RST;
         cfg_ff.upper_limit  <= hbrc_pkg::UPPER_RST;
         cfg_ff.lower_limit  <= hbrc_pkg::LOWER_RST;
         cfg_ff.timeout_ms   <= hbrc_pkg::TIMEOUT_RST;
         cfg_ff.common_anode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/hbrc_state.sv =====
// ----------------------------------------------------------------------------
// hbrc_state
// mode, watchdog timer and colour state with the per-word update logic
// ----------------------------------------------------------------------------
`default_nettype none

module hbrc_state (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire hbrc_pkg::cfg_type                  cfg,
   input  wire logic                               fire,
   input  wire logic                               kind,
   input  wire logic [hbrc_pkg::LEVEL_BITS-1:0]    humidity,
   output hbrc_pkg::result_type                    result
);

   logic [hbrc_pkg::MODE_BITS-1:0]   mode_ff,   mode_in;
   logic [hbrc_pkg::TIMER_BITS-1:0]  quiet_ff,  quiet_in;
   logic [hbrc_pkg::COLOUR_BITS-1:0] colour_ff, colour_in;

   logic [hbrc_pkg::TIMER_BITS-1:0]  quiet_inc;
   logic                             expired;
   logic                             rejudge;
   logic [hbrc_pkg::MODE_BITS-1:0]   judge_mode;
   logic [hbrc_pkg::COLOUR_BITS-1:0] judge_colour;
   logic                             fired;
   logic [3*hbrc_pkg::LED_BITS-1:0]  rgb;

   // saturating watchdog increment
   assign quiet_inc = (quiet_ff == {hbrc_pkg::TIMER_BITS{1'b1}}) ?
                      quiet_ff : quiet_ff + hbrc_pkg::TIMER_BITS'(1);
   assign expired   = hbrc_pkg::CMP_BITS'(quiet_inc) >= hbrc_pkg::CMP_BITS'(cfg.timeout_ms);

   // idle band judgement, upper limit tested first
   always_comb begin
      if (humidity > cfg.upper_limit) begin
         judge_mode   = hbrc_pkg::MODE_DEHUM;
         judge_colour = hbrc_pkg::COL_RED;
      end else if (humidity < cfg.lower_limit) begin
         judge_mode   = hbrc_pkg::MODE_HUM;
         judge_colour = hbrc_pkg::COL_AQUA;
      end else begin
         judge_mode   = hbrc_pkg::MODE_IDLE;
         judge_colour = hbrc_pkg::COL_GREEN;
      end
   end

   always_comb begin
      rejudge   = 1'b0;
      mode_in   = mode_ff;
      colour_in = colour_ff;
      quiet_in  = quiet_ff;
      fired     = 1'b0;
      if (kind == hbrc_pkg::KIND_SAMPLE) begin
         quiet_in = '0;
         unique case (mode_ff)
            hbrc_pkg::MODE_DEHUM: rejudge = humidity <= cfg.target_level;
            hbrc_pkg::MODE_HUM:   rejudge = humidity >= cfg.target_level;
            hbrc_pkg::MODE_IDLE:  rejudge = 1'b1;
            default: begin
               mode_in   = hbrc_pkg::MODE_IDLE;
               colour_in = hbrc_pkg::COL_ERROR;
            end
         endcase
         if (rejudge) begin
            mode_in   = judge_mode;
            colour_in = judge_colour;
         end
      end else begin
         quiet_in = quiet_inc;
         if (expired) begin
            mode_in   = hbrc_pkg::MODE_IDLE;
            colour_in = hbrc_pkg::COL_PURPLE;
            fired     = 1'b1;
         end
      end
   end

   assign rgb = hbrc_pkg::colour_rgb(colour_in) ^ {(3*hbrc_pkg::LED_BITS){cfg.common_anode}};

   always_comb begin
      result.humidifier_on   = mode_in == hbrc_pkg::MODE_HUM;
      result.dehumidifier_on = mode_in == hbrc_pkg::MODE_DEHUM;
      result.mode            = mode_in;
      result.timed_out       = fired;
      result.led_red         = rgb[3*hbrc_pkg::LED_BITS-1:2*hbrc_pkg::LED_BITS];
      result.led_green       = rgb[2*hbrc_pkg::LED_BITS-1:hbrc_pkg::LED_BITS];
      result.led_blue        = rgb[hbrc_pkg::LED_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= hbrc_pkg::MODE_IDLE;
         quiet_ff  <= '0;
         colour_ff <= hbrc_pkg::COL_ORANGE;
      end else if (fire) begin
         mode_ff   <= mode_in;
         quiet_ff  <= quiet_in;
         colour_ff <= colour_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/humidity_band_relay_controller.sv =====
// timing: an accepted word is held in the input register, and its result is registered
// in the result register once that register can take it; one word per cycle while rsp_stall is low
// the result register frees the input register whenever it is empty or taken
// reset: synchronous active high, clears mode to idle, timer to zero,
// colour to orange, pipeline valids and all configuration to defaults
// ----------------------------------------------------------------------------
// humidity_band_relay_controller
// hysteresis humidity relay control with a millisecond watchdog
// ----------------------------------------------------------------------------
`default_nettype none

`include "humidity_band_relay_controller_macros.svh"

module humidity_band_relay_controller (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_kind,
   input  wire logic [hbrc_pkg::LEVEL_BITS-1:0]     req_humidity,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_humidifier_on,
   output logic                                     rsp_dehumidifier_on,
   output logic [hbrc_pkg::MODE_BITS-1:0]           rsp_mode,
   output logic                                     rsp_timed_out,
   output logic [hbrc_pkg::LED_BITS-1:0]            rsp_led_red,
   output logic [hbrc_pkg::LED_BITS-1:0]            rsp_led_green,
   output logic [hbrc_pkg::LED_BITS-1:0]            rsp_led_blue,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [hbrc_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [hbrc_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   hbrc_pkg::cfg_type    cfg;
   hbrc_pkg::result_type result;
   hbrc_pkg::result_type out_ff;

   logic                              in_vld_ff, in_vld_in;
   logic                              in_kind_ff;
   logic [hbrc_pkg::LEVEL_BITS-1:0]   in_hum_ff;
   logic                              out_vld_ff, out_vld_in;
   logic                              advance;
   logic                              fire;
   logic                              take;

   hbrc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   hbrc_state u_state (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .fire     (fire),
      .kind     (in_kind_ff),
      .humidity (in_hum_ff),
      .result   (result)
   );

   // result register can take a new word when empty or being drained
   assign advance   = !out_vld_ff || !rsp_stall;
   assign fire      = in_vld_ff && advance;
   assign req_stall = in_vld_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (take) begin
         in_vld_in = 1'b1;
      end else if (fire) begin
         in_vld_in = 1'b0;
      end
      out_vld_in = advance ? in_vld_ff : out_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_kind_ff <= req_kind;
         in_hum_ff  <= req_humidity;
      end
      if (fire) begin
         out_ff <= result;
      end
   end

   assign rsp_valid           = out_vld_ff;
   assign rsp_humidifier_on   = out_ff.humidifier_on;
   assign rsp_dehumidifier_on = out_ff.dehumidifier_on;
   assign rsp_mode            = out_ff.mode;
   assign rsp_timed_out       = out_ff.timed_out;
   assign rsp_led_red         = out_ff.led_red;
   assign rsp_led_green       = out_ff.led_green;
   assign rsp_led_blue        = out_ff.led_blue;

   `HBRC_ASSERT_IMPLY(a_timeout_idle, clock, reset, rsp_valid && rsp_timed_out, rsp_mode == hbrc_pkg::MODE_IDLE)
   `HBRC_ASSERT_IMPLY(a_full_stalls, clock, reset, in_vld_ff && out_vld_ff && rsp_stall, req_stall)
   `HBRC_ASSERT_IMPLY(a_relay_follows_mode, clock, reset, rsp_valid, rsp_humidifier_on == (rsp_mode == hbrc_pkg::MODE_HUM))
   `HBRC_ASSERT_NEVER(a_relays_exclusive, clock, reset, rsp_valid && rsp_humidifier_on && rsp_dehumidifier_on)

endmodule

`default_nettype wire
